FILE: design/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and constants for radial_to_planar_depth
// Register indexes, field widths and the front-to-back job record.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int DEPTH_BITS = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 13;
   // f^2 reaches 2^24 at f = -4096, so squares need 25 bits; den stays below 3*2^48
   localparam int SQ_BITS  = 25;
   localparam int DEN_BITS = 2 * SQ_BITS;
   // wide products are split into a low and a high half of den or num
   localparam int HALF_BITS = 25;
   localparam int PART_BITS = 2 * DEPTH_BITS + HALF_BITS;
   // q^2 * den stays below 2^82
   localparam int NUM_BITS = 82;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER_X     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CENTER_Y     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_FOCAL_X      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_FOCAL_Y      = 3'd5;

   // Job handed from the front to the back
   typedef struct packed {
      logic [DEPTH_BITS-1:0]     depth;
      logic signed [SIZE_BITS:0] du;
      logic signed [SIZE_BITS:0] dv;
      logic                      frame_end;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_MUL, ST_SUM, ST_ITER, ST_PROD, ST_CMP, ST_DONE
   } back_state_type;

endpackage

FILE: design/rpd_front.sv
// ----------------------------------------------------------------------------
// rpd_front: pixel position tracking
// Accepts depth pixels, steps column/row counters and builds job records.
// ----------------------------------------------------------------------------
module rpd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rpd_pkg::DEPTH_BITS-1:0]   req_ray_depth,
   input  logic [rpd_pkg::SIZE_BITS-1:0]    frame_width,
   input  logic [rpd_pkg::SIZE_BITS-1:0]    frame_height,
   input  logic [rpd_pkg::COORD_BITS-1:0]   center_x,
   input  logic [rpd_pkg::COORD_BITS-1:0]   center_y,
   input  logic                             q_full,
   output logic                             q_push,
   output rpd_pkg::job_type                 q_job
);

   logic [rpd_pkg::COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [rpd_pkg::SIZE_BITS-1:0]  w_eff, h_eff;
   logic [rpd_pkg::SIZE_BITS-1:0]  col_nx, row_nx;
   logic                           last_col, last_row;

   // Clamp frame size into 1..4096
   always_comb begin
      w_eff = frame_width;
      if (frame_width == '0) w_eff = rpd_pkg::SIZE_BITS'(1);
      else if (frame_width > (rpd_pkg::SIZE_BITS'(1) << rpd_pkg::COORD_BITS))
         w_eff = rpd_pkg::SIZE_BITS'(1) << rpd_pkg::COORD_BITS;
      h_eff = frame_height;
      if (frame_height == '0) h_eff = rpd_pkg::SIZE_BITS'(1);
      else if (frame_height > (rpd_pkg::SIZE_BITS'(1) << rpd_pkg::COORD_BITS))
         h_eff = rpd_pkg::SIZE_BITS'(1) << rpd_pkg::COORD_BITS;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign col_nx    = {1'b0, col_ff} + rpd_pkg::SIZE_BITS'(1);
   assign row_nx    = {1'b0, row_ff} + rpd_pkg::SIZE_BITS'(1);
   assign last_col  = col_nx >= w_eff;
   assign last_row  = row_nx >= h_eff;

   // Build the job record
   always_comb begin
      q_job.depth     = req_ray_depth;
      q_job.du        = $signed({2'b00, col_ff}) - $signed({2'b00, center_x});
      q_job.dv        = $signed({2'b00, row_ff}) - $signed({2'b00, center_y});
      q_job.frame_end = last_col && last_row;
   end

   // Advance counters on each transfer
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_nx[rpd_pkg::COORD_BITS-1:0];
         end else begin
            col_in = col_nx[rpd_pkg::COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: design/rpd_queue.sv
// ----------------------------------------------------------------------------
// rpd_queue: two-entry job queue
// Decouples the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module rpd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rpd_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output rpd_pkg::job_type pop_job
);

   rpd_pkg::job_type slot_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_job   = slot_ff[rd_ff];

   // Move pointers and count
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

FILE: design/rpd_back.sv
// ----------------------------------------------------------------------------
// rpd_back: planar depth solver
// Forms the squared terms, then finds q bit by bit with q^2*den <= d^2*num.
// ----------------------------------------------------------------------------
module rpd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [rpd_pkg::SIZE_BITS-1:0] focal_x,
   input  logic signed [rpd_pkg::SIZE_BITS-1:0] focal_y,
   input  logic                                job_avail,
   input  rpd_pkg::job_type                    job,
   output logic                                job_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rpd_pkg::DEPTH_BITS-1:0]      rsp_planar_depth,
   output logic                                rsp_frame_end
);

   localparam int BIT_W = $clog2(rpd_pkg::DEPTH_BITS);
   localparam int DB    = rpd_pkg::DEPTH_BITS;
   localparam int DD_W  = 2 * rpd_pkg::DEPTH_BITS;
   localparam int SQ_W  = rpd_pkg::SQ_BITS;
   localparam int DEN_W = rpd_pkg::DEN_BITS;
   localparam int HB    = rpd_pkg::HALF_BITS;
   localparam int PT_W  = rpd_pkg::PART_BITS;
   localparam int NUM_W = rpd_pkg::NUM_BITS;

   rpd_pkg::back_state_type state_ff, state_in;

   logic [DB-1:0]                 d_ff, q_ff, q_in, out_ff, out_in;
   logic                          fe_ff, zero_ff, ofe_ff, ofe_in, vld_ff, vld_in;
   logic [rpd_pkg::SIZE_BITS-1:0] ax, ay, adu, adv;
   logic [SQ_W-1:0]               fx2_ff, fy2_ff, du2_ff, dv2_ff;
   logic [DEN_W-1:0]              t1_ff, t2_ff, nf_ff, den_ff;
   logic [DD_W-1:0]               dd_ff, cc_ff;
   logic [PT_W-1:0]               rlo_ff, rhi_ff, plo_ff, phi_ff;
   logic [NUM_W-1:0]              rhs_ff, lhs;
   logic [BIT_W-1:0]              bit_ff, bit_in;
   logic [DB-1:0]                 cand;
   logic                          load, sq, mul, sum, iter, prod;

   assign ax  = focal_x[rpd_pkg::SIZE_BITS-1] ? rpd_pkg::SIZE_BITS'(-focal_x)
                                             : rpd_pkg::SIZE_BITS'(focal_x);
   assign ay  = focal_y[rpd_pkg::SIZE_BITS-1] ? rpd_pkg::SIZE_BITS'(-focal_y)
                                             : rpd_pkg::SIZE_BITS'(focal_y);
   assign adu = job.du[rpd_pkg::SIZE_BITS] ? rpd_pkg::SIZE_BITS'(-job.du)
                                          : rpd_pkg::SIZE_BITS'(job.du);
   assign adv = job.dv[rpd_pkg::SIZE_BITS] ? rpd_pkg::SIZE_BITS'(-job.dv)
                                          : rpd_pkg::SIZE_BITS'(job.dv);
   assign cand = q_ff | (DB'(1) << bit_ff);

   // Join the two half products of the candidate test
   assign lhs = NUM_W'(plo_ff) + (NUM_W'(phi_ff) << HB);

   assign rsp_valid        = vld_ff;
   assign rsp_planar_depth = out_ff;
   assign rsp_frame_end    = ofe_ff;

   // Sequence one job: square, multiply, sum, then search bit by bit in ITER, PROD and CMP
   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      q_in     = q_ff;
      out_in   = out_ff;
      ofe_in   = ofe_ff;
      vld_in   = vld_ff && rsp_stall;
      job_pop  = 1'b0;
      load = 1'b0; sq = 1'b0; mul = 1'b0; sum = 1'b0; iter = 1'b0; prod = 1'b0;
      unique case (state_ff)
         rpd_pkg::ST_IDLE: begin
            if (job_avail) begin
               job_pop  = 1'b1;
               load     = 1'b1;
               state_in = rpd_pkg::ST_SQ;
            end
         end
         rpd_pkg::ST_SQ: begin
            sq = 1'b1;
            state_in = rpd_pkg::ST_MUL;
         end
         rpd_pkg::ST_MUL: begin
            mul = 1'b1;
            state_in = rpd_pkg::ST_SUM;
         end
         rpd_pkg::ST_SUM: begin
            sum    = 1'b1;
            q_in   = '0;
            bit_in = BIT_W'(DB - 1);
            state_in = zero_ff ? rpd_pkg::ST_DONE : rpd_pkg::ST_ITER;
         end
         rpd_pkg::ST_ITER: begin
            iter = 1'b1;
            if (cand > d_ff) begin
               if (bit_ff == '0) state_in = rpd_pkg::ST_DONE;
               else bit_in = bit_ff - BIT_W'(1);
            end else begin
               state_in = rpd_pkg::ST_PROD;
            end
         end
         rpd_pkg::ST_PROD: begin
            prod = 1'b1;
            state_in = rpd_pkg::ST_CMP;
         end
         rpd_pkg::ST_CMP: begin
            if (lhs <= rhs_ff) q_in = cand;
            if (bit_ff == '0) state_in = rpd_pkg::ST_DONE;
            else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = rpd_pkg::ST_ITER;
            end
         end
         rpd_pkg::ST_DONE: begin
            if (!vld_ff || !rsp_stall) begin
               out_in   = zero_ff ? '0 : q_ff;
               ofe_in   = fe_ff;
               vld_in   = 1'b1;
               state_in = rpd_pkg::ST_IDLE;
            end
         end
         default: state_in = rpd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpd_pkg::ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      q_ff   <= q_in;
      out_ff <= out_in;
      ofe_ff <= ofe_in;
      if (load) begin
         d_ff    <= job.depth;
         fe_ff   <= job.frame_end;
         zero_ff <= (ax == '0) || (ay == '0);
         du2_ff  <= SQ_W'(adu) * SQ_W'(adu);
         dv2_ff  <= SQ_W'(adv) * SQ_W'(adv);
         fx2_ff  <= SQ_W'(ax) * SQ_W'(ax);
         fy2_ff  <= SQ_W'(ay) * SQ_W'(ay);
      end
      if (sq) begin
         t1_ff <= DEN_W'(du2_ff) * DEN_W'(fy2_ff);
         t2_ff <= DEN_W'(dv2_ff) * DEN_W'(fx2_ff);
         nf_ff <= DEN_W'(fx2_ff) * DEN_W'(fy2_ff);
         dd_ff <= DD_W'(d_ff) * DD_W'(d_ff);
      end
      // Sum the divisor terms, split d^2 * num into two half products
      if (mul) begin
         den_ff <= t1_ff + t2_ff + nf_ff;
         rlo_ff <= PT_W'(dd_ff) * PT_W'(nf_ff[HB-1:0]);
         rhi_ff <= PT_W'(dd_ff) * PT_W'(nf_ff[DEN_W-1:HB]);
      end
      if (sum) rhs_ff <= NUM_W'(rlo_ff) + (NUM_W'(rhi_ff) << HB);
      if (iter) cc_ff <= DD_W'(cand) * DD_W'(cand);
      // Split candidate^2 * den into two half products
      if (prod) begin
         plo_ff <= PT_W'(cc_ff) * PT_W'(den_ff[HB-1:0]);
         phi_ff <= PT_W'(cc_ff) * PT_W'(den_ff[DEN_W-1:HB]);
      end
   end

endmodule

FILE: design/radial_to_planar_depth.sv
// ----------------------------------------------------------------------------
// radial_to_planar_depth: ray depth to planar depth converter
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_ray_depth
//   rsp     | out       | rsp_valid/rsp_stall | rsp_planar_depth, rsp_frame_end
//   csr     | in        | csr_write           | csr_index, csr_data
//
// The back solver runs SQ, MUL, SUM, then per result bit ITER, plus PROD and CMP
// when the candidate is within the depth, and DONE; zero focal length skips the bits.
// The front accepts pixels into a two-entry queue while the back is busy.
// Reset is synchronous; registers return to 640x480, centre 320/240, f -600/600.
// A stalled result holds in its output register and keeps the back waiting.
// ----------------------------------------------------------------------------
module radial_to_planar_depth (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rpd_pkg::DEPTH_BITS-1:0]      req_ray_depth,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rpd_pkg::DEPTH_BITS-1:0]      rsp_planar_depth,
   output logic                                rsp_frame_end,
   input  logic                                csr_write,
   input  logic [rpd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rpd_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic [rpd_pkg::SIZE_BITS-1:0]  width_ff, height_ff, fx_ff, fy_ff;
   logic [rpd_pkg::COORD_BITS-1:0] cx_ff, cy_ff;
   logic                           q_full, q_push, q_avail, q_pop;
   rpd_pkg::job_type               push_job, pop_job;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rpd_pkg::SIZE_BITS'(640);
         height_ff <= rpd_pkg::SIZE_BITS'(480);
         cx_ff     <= rpd_pkg::COORD_BITS'(320);
         cy_ff     <= rpd_pkg::COORD_BITS'(240);
         fx_ff     <= rpd_pkg::SIZE_BITS'(8192 - 600);
         fy_ff     <= rpd_pkg::SIZE_BITS'(600);
      end else if (csr_write) begin
         unique case (csr_index)
            rpd_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_data;
            rpd_pkg::REG_FRAME_HEIGHT: height_ff <= csr_data;
            rpd_pkg::REG_CENTER_X:     cx_ff     <= csr_data[rpd_pkg::COORD_BITS-1:0];
            rpd_pkg::REG_CENTER_Y:     cy_ff     <= csr_data[rpd_pkg::COORD_BITS-1:0];
            rpd_pkg::REG_FOCAL_X:      fx_ff     <= csr_data;
            rpd_pkg::REG_FOCAL_Y:      fy_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   rpd_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_ray_depth,
      .frame_width(width_ff), .frame_height(height_ff),
      .center_x(cx_ff), .center_y(cy_ff),
      .q_full, .q_push, .q_job(push_job)
   );

   rpd_queue u_queue (
      .clock, .reset, .push(q_push), .push_job, .full(q_full),
      .pop(q_pop), .not_empty(q_avail), .pop_job
   );

   rpd_back u_back (
      .clock, .reset,
      .focal_x(fx_ff), .focal_y(fy_ff),
      .job_avail(q_avail), .job(pop_job), .job_pop(q_pop),
      .rsp_valid, .rsp_stall, .rsp_planar_depth, .rsp_frame_end
   );

`ifndef NO_ASSERTIONS
   // Queue never popped while empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_avail) else $error("pop from empty queue");
   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_planar_depth))
      else $error("stalled result changed");
   // Input stalls exactly when the queue is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall == q_full) else $error("stall does not follow queue");
`endif

endmodule

FILE: verif/rpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_checker: planar depth predictor and result comparator
// Mirrors the register writes and the pixel counters, works out the planar
// depth of each accepted pixel and compares it with the returned results.
// ----------------------------------------------------------------------------
module rpd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [rpd_pkg::DEPTH_BITS-1:0]    req_ray_depth,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rpd_pkg::DEPTH_BITS-1:0]    rsp_planar_depth,
   input  logic                              rsp_frame_end,
   input  logic                              csr_write,
   input  logic [rpd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rpd_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                fail_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [rpd_pkg::DEPTH_BITS-1:0] depth;
      logic                           frame_end;
   } pixel_result_type;

   logic [rpd_pkg::SIZE_BITS-1:0]  width_reg, height_reg, focal_x_reg, focal_y_reg;
   logic [rpd_pkg::COORD_BITS-1:0] centre_x_reg, centre_y_reg, column_pos, row_pos;
   pixel_result_type               expected_pixels[$];

   function automatic longint size_of(logic [rpd_pkg::SIZE_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > (1 << rpd_pkg::COORD_BITS)) return 1 << rpd_pkg::COORD_BITS;
      return longint'(raw);
   endfunction

   // largest q <= d with q^2 * den <= d^2 * fx^2 * fy^2; zero if a focal length is zero
   function automatic logic [rpd_pkg::DEPTH_BITS-1:0] planar_depth_of(
         logic [rpd_pkg::DEPTH_BITS-1:0] d, longint col, longint row);
      longint fx, fy, du, dv;
      logic [127:0] den, rhs, c;
      logic [rpd_pkg::DEPTH_BITS-1:0] q;
      fx = longint'($signed(focal_x_reg));
      fy = longint'($signed(focal_y_reg));
      du = col - longint'(centre_x_reg);
      dv = row - longint'(centre_y_reg);
      q  = '0;
      if (fx == 0 || fy == 0) return '0;
      den = 128'(du * du * fy * fy) + 128'(dv * dv * fx * fx) + 128'(fx * fx * fy * fy);
      rhs = 128'(d) * 128'(d) * 128'(fx * fx) * 128'(fy * fy);
      for (int b = rpd_pkg::DEPTH_BITS - 1; b >= 0; b--) begin
         c = 128'(q | (1 << b));
         if (c <= 128'(d) && c * c * den <= rhs) q = c[rpd_pkg::DEPTH_BITS-1:0];
      end
      return q;
   endfunction

   assign pending_count = expected_pixels.size();

   // track registers, predict on each request transfer, check each result
   always @(posedge clock) begin
      pixel_result_type got, want;
      longint w, h;
      logic last_col, last_row;
      if (reset) begin
         width_reg    <= 13'd640;
         height_reg   <= 13'd480;
         centre_x_reg <= 12'd320;
         centre_y_reg <= 12'd240;
         focal_x_reg  <= -13'sd600;
         focal_y_reg  <= 13'd600;
         column_pos   <= '0;
         row_pos      <= '0;
         fail_count   <= 0;
         expected_pixels.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               rpd_pkg::REG_FRAME_WIDTH:  width_reg    <= csr_data;
               rpd_pkg::REG_FRAME_HEIGHT: height_reg   <= csr_data;
               rpd_pkg::REG_CENTER_X:
                  centre_x_reg <= csr_data[rpd_pkg::COORD_BITS-1:0];
               rpd_pkg::REG_CENTER_Y:
                  centre_y_reg <= csr_data[rpd_pkg::COORD_BITS-1:0];
               rpd_pkg::REG_FOCAL_X:      focal_x_reg  <= csr_data;
               rpd_pkg::REG_FOCAL_Y:      focal_y_reg  <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            w = size_of(width_reg);
            h = size_of(height_reg);
            last_col = longint'(column_pos) + 1 >= w;
            last_row = longint'(row_pos) + 1 >= h;
            want.depth     = planar_depth_of(req_ray_depth, longint'(column_pos),
                                             longint'(row_pos));
            want.frame_end = last_col && last_row;
            expected_pixels.push_back(want);
            if (last_col) begin
               column_pos <= '0;
               row_pos    <= last_row ? '0 : row_pos + 1'b1;
            end else begin
               column_pos <= column_pos + 1'b1;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.depth     = rsp_planar_depth;
            got.frame_end = rsp_frame_end;
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: depth %0d end %0b", got.depth, got.frame_end);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected depth %0d end %0b, got depth %0d end %0b",
                              want.depth, want.frame_end, got.depth, got.frame_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: verif/tb_radial_to_planar_depth.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_to_planar_depth: stimulus and verdict for the depth converter
// Drives directed and random depth pixels through several camera settings
// with bursty requests and patterned stalls; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_radial_to_planar_depth;

   // register indexes with no register behind them
   localparam logic [rpd_pkg::CSR_IDX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [rpd_pkg::CSR_IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

   logic                              clock, reset;
   logic                              req_valid, req_stall;
   logic [rpd_pkg::DEPTH_BITS-1:0]    req_ray_depth;
   logic                              rsp_valid, rsp_stall;
   logic [rpd_pkg::DEPTH_BITS-1:0]    rsp_planar_depth;
   logic                              rsp_frame_end;
   logic                              csr_write;
   logic [rpd_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [rpd_pkg::CSR_DATA_BITS-1:0] csr_data;
   int                                fail_count, pending_count;
   int                                cycle_count;
   int                                stall_mode;

   radial_to_planar_depth dut (.*);

   rpd_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // stop a hung run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 900000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver stalls: a pattern that changes its mode now and then
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= (cycle_count % 7 < 3);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   task automatic write_reg(logic [rpd_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [rpd_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // hold the pixel until transferred; valid stays high for a following pixel
   task automatic send_pixel(logic [rpd_pkg::DEPTH_BITS-1:0] d);
      req_valid     <= 1'b1;
      req_ray_depth <= d;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_burst(int count);
      int burst;
      int gap;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         logic [rpd_pkg::DEPTH_BITS-1:0] d;
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap   = $urandom_range(0, 3) * (i % 3);
            // idle between bursts; with no gap the bursts run together
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         case ($urandom_range(0, 5))
            0: d = 16'hFFFF;
            1: d = 16'h0000;
            default: d = rpd_pkg::DEPTH_BITS'($urandom);
         endcase
         burst--;
         send_pixel(d);
      end
   endtask

   // drop valid and wait for every result
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic set_camera(int w, int h, int cx, int cy, int fx, int fy);
      write_reg(rpd_pkg::REG_FRAME_WIDTH, rpd_pkg::CSR_DATA_BITS'(w));
      write_reg(rpd_pkg::REG_FRAME_HEIGHT, rpd_pkg::CSR_DATA_BITS'(h));
      write_reg(rpd_pkg::REG_CENTER_X, rpd_pkg::CSR_DATA_BITS'(cx));
      write_reg(rpd_pkg::REG_CENTER_Y, rpd_pkg::CSR_DATA_BITS'(cy));
      write_reg(rpd_pkg::REG_FOCAL_X, rpd_pkg::CSR_DATA_BITS'(fx));
      write_reg(rpd_pkg::REG_FOCAL_Y, rpd_pkg::CSR_DATA_BITS'(fy));
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_ray_depth = '0;
      csr_write = 1'b0; csr_index = '0; csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, depth extremes
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'h8001);
      drain();
      // tiny frame, far principal point, extreme focal lengths
      set_camera(3, 2, 4095, 4095, 13'h1000, 1);
      for (int i = 0; i < 7; i++) send_pixel(i[0] ? 16'hFFFF : 16'h5555);
      drain();
      // zero focal length, zero frame size, out of range index
      set_camera(0, 0, 0, 0, 0, 4095);
      write_reg(REG_UNMAPPED_HI, 13'h1FFF);
      write_reg(REG_UNMAPPED_LO, 13'h0);
      for (int i = 0; i < 3; i++) send_pixel(16'hFFFF);
      drain();
      write_reg(rpd_pkg::REG_FOCAL_X, 13'h0FFF);
      write_reg(rpd_pkg::REG_FOCAL_Y, '0);
      send_pixel(16'h1234);
      drain();
      // oversized frame, then shrink mid frame
      set_camera(13'h1FFF, 13'h1FFF, 2048, 2048, 1, 13'h1FFF);
      for (int i = 0; i < 5; i++) send_pixel(16'hFFFF);
      drain();
      set_camera(2, 2, 1, 0, 7, 13'h1FF9);
      for (int i = 0; i < 5; i++) send_pixel(16'hAAAA);
      drain();

      // random phases
      for (int p = 0; p < 15; p++) begin
         case (p % 3)
            0: set_camera($urandom_range(1, 40), $urandom_range(1, 10), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 8191),
                          $urandom_range(0, 8191));
            1: set_camera($urandom_range(0, 8191), $urandom_range(0, 8191),
                          $urandom_range(0, 30), $urandom_range(0, 10),
                          $urandom_range(1, 8), $urandom_range(8184, 8191));
            default: set_camera($urandom_range(1, 16), $urandom_range(1, 8),
                                $urandom_range(0, 16), $urandom_range(0, 8),
                                $urandom_range(4000, 4200), $urandom_range(1, 4095));
         endcase
         send_burst(100);
         drain();
      end

      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
